// ----- design/afu_pkg.sv -----
// ----------------------------------------------------------------------------
// afu_pkg: shared types and constants of the activation function unit
// Fixed-point formats, mode codes, pipeline dimensions and the exp(-1)
// constant that the exponential chain multiplies by.
// ----------------------------------------------------------------------------
package afu_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	// internal unsigned fixed point with QW fraction bits
	localparam int QW = 30;
	localparam logic [63:0] QONE = 64'd1 << QW;
	localparam logic [63:0] Q60  = 64'd1 << 60;

	localparam int TERMS     = 16;	// Taylor terms of exp(r)
	localparam int EXP_N_MAX = 40;	// exp(-t) is zero from this integer part on
	localparam int N_W       = 6;
	localparam int R_W       = QW;

	// divider geometry: 61-bit dividend, 32-bit divisor, 31-bit quotient
	localparam int NUM_W = 61;
	localparam int DEN_W = 32;
	localparam int QUO_W = 31;

	typedef enum logic [2:0] {
		MODE_STEP  = 3'd0,
		MODE_RELU  = 3'd1,
		MODE_SRELU = 3'd2,
		MODE_GAUSS = 3'd3,
		MODE_TANH  = 3'd4,
		MODE_SWISH = 3'd5
	} mode_t;

	// 2^60 / exp(1), with exp(1) from the same truncated series as the datapath;
	// with r = 1 each term is the previous one divided by its index
	localparam logic [63:0] E_T1  = QONE;
	localparam logic [63:0] E_T2  = E_T1 / 64'd2;
	localparam logic [63:0] E_T3  = E_T2 / 64'd3;
	localparam logic [63:0] E_T4  = E_T3 / 64'd4;
	localparam logic [63:0] E_T5  = E_T4 / 64'd5;
	localparam logic [63:0] E_T6  = E_T5 / 64'd6;
	localparam logic [63:0] E_T7  = E_T6 / 64'd7;
	localparam logic [63:0] E_T8  = E_T7 / 64'd8;
	localparam logic [63:0] E_T9  = E_T8 / 64'd9;
	localparam logic [63:0] E_T10 = E_T9 / 64'd10;
	localparam logic [63:0] E_T11 = E_T10 / 64'd11;
	localparam logic [63:0] E_T12 = E_T11 / 64'd12;
	localparam logic [63:0] E_T13 = E_T12 / 64'd13;
	localparam logic [63:0] E_T14 = E_T13 / 64'd14;
	localparam logic [63:0] E_T15 = E_T14 / 64'd15;
	localparam logic [63:0] E_T16 = E_T15 / 64'd16;
	localparam logic [63:0] E_SUM = QONE + E_T1 + E_T2 + E_T3 + E_T4 + E_T5 + E_T6
		+ E_T7 + E_T8 + E_T9 + E_T10 + E_T11 + E_T12 + E_T13 + E_T14 + E_T15 + E_T16;

	localparam logic [63:0] EINV_FULL = Q60 / E_SUM;
	localparam logic [29:0] EINV      = EINV_FULL[29:0];

endpackage

// ----- design/afu_div.sv -----
// ----------------------------------------------------------------------------
// afu_div: pipelined restoring divider
// One quotient bit per stage; a tag travels alongside each operand pair.
// ----------------------------------------------------------------------------
module afu_div #(
	parameter int TAG_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [afu_pkg::NUM_W-1:0]   in_num,
	input  logic [afu_pkg::DEN_W-1:0]   in_den,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_valid,
	output logic [afu_pkg::QUO_W-1:0]   out_quo,
	output logic [TAG_W-1:0]            out_tag
);
	import afu_pkg::*;

	logic [DEN_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] low_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic [TAG_W-1:0] tag_s [0:QUO_W];
	logic             vld_s [0:QUO_W];

	// the quotient fits QUO_W bits, so the upper dividend bits start as remainder
	assign rem_s[0] = DEN_W'(in_num[NUM_W-1:QUO_W]);
	assign low_s[0] = in_num[QUO_W-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;
	assign vld_s[0] = in_valid;

	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {rem_s[j], low_s[j][QUO_W-1]};
		assign ge    = trial >= {1'b0, den_s[j]};
		assign diff  = trial - {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_s[j+1] <= {low_s[j][QUO_W-2:0], 1'b0};
			quo_s[j+1] <= {quo_s[j][QUO_W-2:0], ge};
			den_s[j+1] <= den_s[j];
			tag_s[j+1] <= tag_s[j];
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];

endmodule

// ----- design/afu_exp.sv -----
// ----------------------------------------------------------------------------
// afu_exp: pipelined exp(-t) in unsigned Q.30
// Taylor series of exp(r) for the fraction, reciprocal by division, then one
// multiply by 1/e per stage for the integer part.
// ----------------------------------------------------------------------------
module afu_exp #(
	parameter int TAG_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [afu_pkg::N_W-1:0]   in_n,
	input  logic                      in_zero,
	input  logic [afu_pkg::R_W-1:0]   in_r,
	input  logic [TAG_W-1:0]          in_tag,
	output logic                      out_valid,
	output logic [30:0]               out_v,
	output logic [TAG_W-1:0]          out_tag
);
	import afu_pkg::*;

	localparam int SIDE_W = TAG_W + 1 + N_W + R_W;
	localparam int MID_W  = TAG_W + 1 + N_W;

	logic [30:0]       tterm_s [0:TERMS];
	logic [31:0]       tsum_s  [0:TERMS];
	logic [SIDE_W-1:0] tside_s [0:TERMS];
	logic              tvld_s  [0:TERMS];

	assign tterm_s[0] = 31'(QONE);
	assign tsum_s[0]  = 32'(QONE);
	assign tside_s[0] = {in_tag, in_zero, in_n, in_r};
	assign tvld_s[0]  = in_valid;

	// each term: multiply by r, divide by K through a reciprocal, correct by one
	for (genvar i = 0; i < TERMS; i++) begin : g_term
		localparam int K = i + 1;
		localparam logic [31:0] RECIP = 32'((64'd1 << 31) / K);

		logic [59:0]       prod_a;
		logic [31:0]       sum_a;
		logic [SIDE_W-1:0] side_a;
		logic              vld_a;
		logic [29:0]       x_b;
		logic [29:0]       qe_b;
		logic [31:0]       sum_b;
		logic [SIDE_W-1:0] side_b;
		logic              vld_b;
		logic [34:0]       mk;
		logic [29:0]       rem;
		logic              adj;
		logic [30:0]       term;

		assign mk   = 35'(qe_b) * 35'(K);
		assign rem  = 30'(35'(x_b) - mk);
		assign adj  = rem >= 30'(K);
		assign term = 31'(qe_b) + 31'(adj);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a        <= 1'b0;
				vld_b        <= 1'b0;
				tvld_s[i+1]  <= 1'b0;
			end else begin
				vld_a        <= tvld_s[i];
				vld_b        <= vld_a;
				tvld_s[i+1]  <= vld_b;
			end
		end

		always_ff @(posedge clk) begin
			prod_a       <= 60'(tterm_s[i]) * 60'(tside_s[i][R_W-1:0]);
			sum_a        <= tsum_s[i];
			side_a       <= tside_s[i];
			x_b          <= prod_a[59:30];
			qe_b         <= 30'((62'(prod_a[59:30]) * 62'(RECIP)) >> 31);
			sum_b        <= sum_a;
			side_b       <= side_a;
			tterm_s[i+1] <= term;
			tsum_s[i+1]  <= sum_b + 32'(term);
			tside_s[i+1] <= side_b;
		end
	end

	logic             dvld;
	logic [QUO_W-1:0] dquo;
	logic [MID_W-1:0] dtag;

	afu_div #(
		.TAG_W (MID_W)
	) u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tvld_s[TERMS]),
		.in_num    (NUM_W'(Q60)),
		.in_den    (tsum_s[TERMS]),
		.in_tag    (tside_s[TERMS][SIDE_W-1:R_W]),
		.out_valid (dvld),
		.out_quo   (dquo),
		.out_tag   (dtag)
	);

	localparam int MSTG = EXP_N_MAX - 1;

	logic [30:0]      mv_s   [0:MSTG];
	logic [MID_W-1:0] mtag_s [0:MSTG];
	logic             mvld_s [0:MSTG];

	assign mv_s[0]   = dquo;
	assign mtag_s[0] = dtag;
	assign mvld_s[0] = dvld;

	// stage i applies the (i+1)-th factor of 1/e when the integer part asks for it
	for (genvar i = 0; i < MSTG; i++) begin : g_einv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mvld_s[i+1] <= 1'b0;
			end else begin
				mvld_s[i+1] <= mvld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (N_W'(i) < mtag_s[i][N_W-1:0]) begin
				mv_s[i+1] <= 31'((62'(mv_s[i]) * 62'(EINV)) >> QW);
			end else begin
				mv_s[i+1] <= mv_s[i];
			end
			mtag_s[i+1] <= mtag_s[i];
		end
	end

	assign out_valid = mvld_s[MSTG];
	assign out_v     = mtag_s[MSTG][N_W] ? '0 : mv_s[MSTG];
	assign out_tag   = mtag_s[MSTG][MID_W-1:N_W+1];

endmodule

// ----- design/activation_function_unit.sv -----
// ----------------------------------------------------------------------------
// activation_function_unit: pipelined fixed-point activation functions
// Step, ReLU, smooth ReLU, Gaussian, tanh and x/(1+exp(-x/2)) on Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   Drive x_value and mode and raise start; the operand transfers at any rising
//   edge with start high. busy stays low, so one operand may transfer every
//   cycle, back to back, with no gaps needed.
//   Each result appears on y_value and saturated for exactly one cycle with
//   done high, in the order in which the operands transferred.
//   The receiver cannot stall the unit; a result not taken in its cycle is gone.
//   Latency is set by the depth of the datapath: 16 square-root stages,
//   48 Taylor stages (multiply, reciprocal multiply, correct per term), two
//   31-stage dividers, 39 stages of 1/e multiplies and a few glue stages.
//   Throughput is one item per cycle for all modes.
//   saturated is high when the rounded result lay outside the signed 16-bit
//   range and y_value was clamped. Modes 6 and 7 return zero.
//   Reset (arst_n low) clears every valid bit at once; items in flight are
//   dropped and no done strobe follows for them.
// ----------------------------------------------------------------------------
module activation_function_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [afu_pkg::DATA_WIDTH-1:0]   x_value,
	input  logic [2:0]                              mode,
	output logic                                    done,
	output logic signed [afu_pkg::DATA_WIDTH-1:0]   y_value,
	output logic                                    saturated
);
	import afu_pkg::*;

	localparam int SQ_BITS = DATA_WIDTH;
	localparam int LATENCY = 2 + SQ_BITS + 1 + 3 * TERMS + QUO_W + (EXP_N_MAX - 1)
		+ 1 + QUO_W + 2;
	localparam int TAG_W   = DATA_WIDTH + 3 + DATA_WIDTH + 1 + SQ_BITS;
	localparam int TAG2_W  = TAG_W + 31;
	localparam int V_W     = DATA_WIDTH + 3;
	localparam int SH      = QW - FRAC_BITS;
	localparam logic [63:0] RND    = 64'd1 << (SH - 1);
	localparam logic [30:0] TWO_SS = 31'(2 << (2 * FRAC_BITS));
	localparam logic [DATA_WIDTH-1:0] GAUSS_LIM = DATA_WIDTH'(6 << FRAC_BITS);
	localparam logic signed [V_W-1:0] VMAX = V_W'((1 << (DATA_WIDTH - 1)) - 1);
	localparam logic signed [V_W-1:0] VMIN = -VMAX - V_W'(1);

	// never holds off an operand
	assign busy = 1'b0;

	// ---- stage 1: capture the operand ----
	logic                         vld_s1;
	logic signed [DATA_WIDTH-1:0] x_s1;
	logic [2:0]                   mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_value;
		mode_s1 <= mode;
	end

	// ---- stage 2: magnitude and radicand x*x + 2*S*S ----
	logic [DATA_WIDTH:0] absx;
	assign absx = x_s1[DATA_WIDTH-1] ? -{x_s1[DATA_WIDTH-1], x_s1} : {1'b0, x_s1};

	logic                         vld_s2;
	logic signed [DATA_WIDTH-1:0] x_s2;
	logic [2:0]                   mode_s2;
	logic [DATA_WIDTH-1:0]        a_s2;
	logic                         neg_s2;
	logic [30:0]                  d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s2    <= x_s1;
		mode_s2 <= mode_s1;
		a_s2    <= absx[DATA_WIDTH-1:0];
		neg_s2  <= x_s1[DATA_WIDTH-1];
		d_s2    <= 31'(32'(absx[DATA_WIDTH-1:0]) * 32'(absx[DATA_WIDTH-1:0])) + TWO_SS;
	end

	// ---- square root: one result bit per stage, largest first ----
	logic                         svld_s [0:SQ_BITS];
	logic signed [DATA_WIDTH-1:0] sx_s   [0:SQ_BITS];
	logic [2:0]                   smode_s[0:SQ_BITS];
	logic [DATA_WIDTH-1:0]        sa_s   [0:SQ_BITS];
	logic                         sneg_s [0:SQ_BITS];
	logic [30:0]                  sd_s   [0:SQ_BITS];
	logic [SQ_BITS-1:0]           sres_s [0:SQ_BITS];

	assign svld_s[0]  = vld_s2;
	assign sx_s[0]    = x_s2;
	assign smode_s[0] = mode_s2;
	assign sa_s[0]    = a_s2;
	assign sneg_s[0]  = neg_s2;
	assign sd_s[0]    = d_s2;
	assign sres_s[0]  = '0;

	for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
		logic [SQ_BITS-1:0] trial;
		logic [31:0]        tsq;

		assign trial = sres_s[j] | (SQ_BITS'(1) << (SQ_BITS - 1 - j));
		assign tsq   = 32'(trial) * 32'(trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				svld_s[j+1] <= 1'b0;
			end else begin
				svld_s[j+1] <= svld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sres_s[j+1]  <= (tsq <= 32'(sd_s[j])) ? trial : sres_s[j];
			sx_s[j+1]    <= sx_s[j];
			smode_s[j+1] <= smode_s[j];
			sa_s[j+1]    <= sa_s[j];
			sneg_s[j+1]  <= sneg_s[j];
			sd_s[j+1]    <= sd_s[j];
		end
	end

	// ---- stage 3: exponent argument per mode, split into integer and fraction ----
	logic [30:0]           sq_a;
	logic [DATA_WIDTH-1:0] a_t;
	logic [DATA_WIDTH-1:0] n_full;
	logic [R_W-1:0]        r_t;

	assign sq_a = sd_s[SQ_BITS] - TWO_SS;
	assign a_t  = sa_s[SQ_BITS];

	always_comb begin
		unique case (smode_s[SQ_BITS])
			MODE_GAUSS: begin
				n_full = DATA_WIDTH'(sq_a >> (2 * FRAC_BITS));
				r_t    = R_W'(sq_a[2*FRAC_BITS-1:0]) << (QW - 2 * FRAC_BITS);
			end
			MODE_TANH: begin
				n_full = a_t >> (FRAC_BITS - 1);
				r_t    = R_W'(a_t[FRAC_BITS-2:0]) << (QW + 1 - FRAC_BITS);
			end
			MODE_SWISH: begin
				n_full = a_t >> (FRAC_BITS + 1);
				r_t    = R_W'(a_t[FRAC_BITS:0]) << (QW - 1 - FRAC_BITS);
			end
			default: begin
				n_full = '0;
				r_t    = '0;
			end
		endcase
	end

	logic             vld_s3;
	logic [N_W-1:0]   n_s3;
	logic             zero_s3;
	logic [R_W-1:0]   r_s3;
	logic [TAG_W-1:0] tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= svld_s[SQ_BITS];
		end
	end

	always_ff @(posedge clk) begin
		n_s3    <= N_W'(n_full);
		zero_s3 <= n_full >= DATA_WIDTH'(EXP_N_MAX);
		r_s3    <= r_t;
		tag_s3  <= {sx_s[SQ_BITS], smode_s[SQ_BITS], a_t, sneg_s[SQ_BITS], sres_s[SQ_BITS]};
	end

	// ---- exp(-t) ----
	logic             evld;
	logic [30:0]      ev;
	logic [TAG_W-1:0] etag;

	afu_exp #(
		.TAG_W (TAG_W)
	) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_n      (n_s3),
		.in_zero   (zero_s3),
		.in_r      (r_s3),
		.in_tag    (tag_s3),
		.out_valid (evld),
		.out_v     (ev),
		.out_tag   (etag)
	);

	// ---- stage 4: divider operands (tanh ratio, logistic reciprocal) ----
	logic              vld_s4;
	logic [NUM_W-1:0]  num_s4;
	logic [DEN_W-1:0]  den_s4;
	logic [TAG2_W-1:0] tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= evld;
		end
	end

	always_ff @(posedge clk) begin
		unique case (etag[TAG_W-DATA_WIDTH-1 -: 3])
			MODE_TANH: begin
				num_s4 <= NUM_W'((QONE - 64'(ev)) << QW);
				den_s4 <= DEN_W'(QONE + 64'(ev));
			end
			MODE_SWISH: begin
				num_s4 <= NUM_W'(Q60);
				den_s4 <= DEN_W'(QONE + 64'(ev));
			end
			default: begin
				num_s4 <= '0;
				den_s4 <= DEN_W'(QONE);
			end
		endcase
		tag_s4 <= {etag, ev};
	end

	logic              dvld;
	logic [QUO_W-1:0]  dquo;
	logic [TAG2_W-1:0] dtag;

	afu_div #(
		.TAG_W (TAG2_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.in_tag    (tag_s4),
		.out_valid (dvld),
		.out_quo   (dquo),
		.out_tag   (dtag)
	);

	// ---- stage 5: per-mode value, swish product ----
	logic signed [DATA_WIDTH-1:0] fx;
	logic [2:0]                   fmode;
	logic [DATA_WIDTH-1:0]        fa;
	logic                         fneg;
	logic [SQ_BITS-1:0]           froot;
	logic [30:0]                  fq;
	logic [30:0]                  ffac;
	logic [V_W-1:0]               srelu_sum;
	logic [V_W-1:0]               mag_g;
	logic [V_W-1:0]               mag_t;
	logic signed [V_W-1:0]        vpre;

	assign {fx, fmode, fa, fneg, froot, fq} = dtag;
	assign ffac      = fneg ? 31'(QONE) - dquo : dquo;
	assign srelu_sum = V_W'(fx) + V_W'(1) + V_W'(froot);
	assign mag_g     = V_W'((64'(fq) + RND) >> SH);
	assign mag_t     = V_W'((64'(dquo) + RND) >> SH);

	always_comb begin
		unique case (fmode)
			MODE_STEP:  vpre = fneg ? '0 : V_W'(1 << FRAC_BITS);
			MODE_RELU:  vpre = (!fneg && fx != '0) ? V_W'(fx) : '0;
			MODE_SRELU: vpre = V_W'(srelu_sum >> 1);
			MODE_GAUSS: vpre = (fa >= GAUSS_LIM) ? '0 : mag_g;
			MODE_TANH:  vpre = fneg ? -mag_t : mag_t;
			default:    vpre = '0;
		endcase
	end

	logic                  vld_s5;
	logic [2:0]            mode_s5;
	logic                  neg_s5;
	logic signed [V_W-1:0] v_s5;
	logic [46:0]           prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= dvld;
		end
	end

	always_ff @(posedge clk) begin
		mode_s5 <= fmode;
		neg_s5  <= fneg;
		v_s5    <= vpre;
		prod_s5 <= 47'(fa) * 47'(ffac);
	end

	// ---- stage 6: round the swish product, clamp, present the result ----
	logic [V_W-1:0]        mag_w;
	logic signed [V_W-1:0] vfin;

	assign mag_w = V_W'((64'(prod_s5) + (QONE >> 1)) >> QW);
	assign vfin  = (mode_s5 == MODE_SWISH) ? (neg_s5 ? -mag_w : mag_w) : v_s5;

	logic                         vld_s6;
	logic signed [DATA_WIDTH-1:0] y_s6;
	logic                         sat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		priority if (vfin > VMAX) begin
			y_s6   <= DATA_WIDTH'(VMAX);
			sat_s6 <= 1'b1;
		end else if (vfin < VMIN) begin
			y_s6   <= DATA_WIDTH'(VMIN);
			sat_s6 <= 1'b1;
		end else begin
			y_s6   <= DATA_WIDTH'(vfin);
			sat_s6 <= 1'b0;
		end
	end

	assign done      = vld_s6;
	assign y_value   = y_s6;
	assign saturated = sat_s6;

	// ---- assertions ----
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result did not arrive after the pipeline latency");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching operand transfer");

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(y_value == DATA_WIDTH'(VMAX) || y_value == DATA_WIDTH'(VMIN)))
		else $error("saturated flag with an unclamped value");

	a_step_vals: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(mode_s5 == MODE_STEP)) |->
			(y_value == '0 || y_value == DATA_WIDTH'(1 << FRAC_BITS)))
		else $error("step mode produced a value other than zero or one");

endmodule

// ----- tb/tb_activation_function_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_activation_function_unit: self-checking bench of the activation unit
// Drives directed corner operands and then random Q8.8 operands in every mode.
// Sender gaps vary by phase. Each operand's expected result is computed by a
// fixed-point predictor and queued. Results are checked in order as done
// strobes arrive.
// ----------------------------------------------------------------------------
module tb_activation_function_unit;
	import afu_pkg::*;

	localparam int  N_RANDOM    = 1400;
	localparam int  DRAIN_WAIT  = 250;	// longer than the pipeline latency
	localparam int  CYCLE_LIMIT = 400000;
	localparam logic [63:0] Q_HALF = 64'd1 << (QW - 1);

	typedef struct {
		logic signed [DATA_WIDTH-1:0] x;
		logic [2:0]                   m;
	} operand_t;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] y;
		logic                         sat;
	} activation_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic signed [DATA_WIDTH-1:0] x_value = '0;
	logic [2:0]                   mode = '0;
	logic                         busy;
	logic                         done;
	logic signed [DATA_WIDTH-1:0] y_value;
	logic                         saturated;

	operand_t    pending_ops[$];
	activation_t expected_acts[$];
	int          transfers = 0;
	int          errors = 0;
	int          cycles = 0;

	activation_function_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.x_value   (x_value),
		.mode      (mode),
		.done      (done),
		.y_value   (y_value),
		.saturated (saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// exp(r) for r in [0,1] in Q.30, truncated Taylor terms
	function automatic logic [63:0] exp_series(logic [63:0] r);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = QONE;
		term = QONE;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * r) >> QW) / 64'(k);
			sum  = sum + term;
		end
		return sum;
	endfunction

	// exp(-t) in Q.30: fractional part by reciprocal, integer part by 1/e steps
	function automatic logic [63:0] exp_decay(logic [63:0] t);
		logic [63:0] n;
		logic [63:0] v;
		logic [63:0] inv_e;
		n = t >> QW;
		if (n >= 64'd40)
			return 64'd0;
		v     = Q60 / exp_series(t & (QONE - 64'd1));
		inv_e = Q60 / exp_series(QONE);
		for (int i = 0; i < int'(n); i++)
			v = (v * inv_e) >> QW;
		return v;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] d);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b    = 64'd1 << 62;
		while (b > d)
			b = b >> 2;
		while (b != 0) begin
			if (d >= root + b) begin
				d    = d - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// round a Q.30 magnitude to Q8.8
	function automatic logic [63:0] to_q88(logic [63:0] q);
		return ((q << FRAC_BITS) + Q_HALF) >> QW;
	endfunction

	function automatic activation_t activate(operand_t op);
		activation_t res;
		longint      xs;
		longint      v;
		logic [63:0] mag;
		logic [63:0] q;
		logic [63:0] th;
		logic [63:0] sg;
		logic [63:0] f;
		bit          neg;
		xs  = longint'(op.x);
		neg = xs < 0;
		mag = neg ? 64'(-xs) : 64'(xs);
		v   = 0;
		case (op.m)
			MODE_STEP:  v = neg ? 0 : (longint'(1) << FRAC_BITS);
			MODE_RELU:  v = (xs > 0) ? xs : 0;
			MODE_SRELU: begin
				q = int_sqrt(mag * mag + 64'd2 * (64'd1 << (2 * FRAC_BITS)));
				v = (xs + 1 + longint'(q)) / 2;
			end
			MODE_GAUSS: begin
				if (mag >= (64'd6 << FRAC_BITS))
					v = 0;
				else
					v = longint'(to_q88(exp_decay((mag * mag) << (QW - 2 * FRAC_BITS))));
			end
			MODE_TANH: begin
				q  = exp_decay(mag << (QW + 1 - FRAC_BITS));
				th = ((QONE - q) << QW) / (QONE + q);
				v  = longint'(to_q88(th));
				if (neg)
					v = -v;
			end
			MODE_SWISH: begin
				q  = exp_decay(mag << (QW - 1 - FRAC_BITS));
				sg = Q60 / (QONE + q);
				f  = neg ? QONE - sg : sg;
				v  = longint'((mag * f + Q_HALF) >> QW);
				if (neg)
					v = -v;
			end
			default: v = 0;
		endcase
		res.sat = 1'b0;
		if (v > 32767) begin
			v       = 32767;
			res.sat = 1'b1;
		end else if (v < -32768) begin
			v       = -32768;
			res.sat = 1'b1;
		end
		res.y = DATA_WIDTH'(v);
		return res;
	endfunction

	function automatic void add_op(logic signed [DATA_WIDTH-1:0] x, logic [2:0] m);
		operand_t op;
		op.x = x;
		op.m = m;
		pending_ops.push_back(op);
	endfunction

	// sender gap rate per phase of the run
	function automatic int gap_pct(int n);
		if (n < 500)
			return 16;
		else if (n < 1000)
			return 87;
		return 0;
	endfunction

	// driver: record a transfer, then present the next operand or drop start
	always @(posedge clk) begin
		operand_t op;
		if (arst_n) begin
			if (start && !busy) begin
				op.x = x_value;
				op.m = mode;
				expected_acts.push_back(activate(op));
				transfers <= transfers + 1;
			end
			if ((!start || !busy) && pending_ops.size() > 0
					&& $urandom_range(99) >= gap_pct(transfers)) begin
				op = pending_ops.pop_front();
				x_value <= op.x;
				mode    <= op.m;
				start   <= 1'b1;
			end else if (!start || !busy) begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check each strobed result against the oldest expectation
	always @(posedge clk) begin
		activation_t exp_act;
		int          bad;
		bad = 0;
		if (arst_n && done) begin
			if (expected_acts.size() == 0) begin
				$error("unexpected result y_value=%0d saturated=%0b", y_value, saturated);
				bad = bad + 1;
			end else begin
				exp_act = expected_acts.pop_front();
				if (y_value !== exp_act.y) begin
					$error("y_value expected %0d actual %0d", exp_act.y, y_value);
					bad = bad + 1;
				end
				if (saturated !== exp_act.sat) begin
					$error("saturated expected %0b actual %0b", exp_act.sat, saturated);
					bad = bad + 1;
				end
			end
		end
		errors <= errors + bad;
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("activation_function_unit: mismatch");
			$finish;
		end
	end

	initial begin
		logic signed [DATA_WIDTH-1:0] xr;
		logic [2:0]                   mr;
		// corners: zero and both extremes in every function
		for (int m = MODE_STEP; m <= MODE_SWISH; m++) begin
			add_op(16'sd0, 3'(m));
			add_op(16'sh7fff, 3'(m));
			add_op(-16'sh8000, 3'(m));
		end
		add_op(16'sd1, MODE_RELU);
		add_op(-16'sd1, MODE_STEP);
		add_op(16'sd1536, MODE_GAUSS);	// Gaussian cut-off at |x| = 6
		add_op(-16'sd1535, MODE_GAUSS);
		add_op(16'sd256, MODE_SRELU);
		add_op(-16'sd600, MODE_TANH);
		add_op(-16'sd1, 3'd6);	// unused codes answer zero
		add_op(16'sh7fff, 3'd7);
		for (int i = 0; i < N_RANDOM; i++) begin
			// mostly the range where the curves bend, some full-scale operands
			if ($urandom_range(99) < 60)
				xr = DATA_WIDTH'($signed($urandom_range(4096)) - 2048);
			else
				xr = DATA_WIDTH'($urandom);
			mr = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 6))
			                              : 3'($urandom_range(5));
			add_op(xr, mr);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() == 0 && !start);
		wait (expected_acts.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && expected_acts.size() == 0)
			$display("activation_function_unit: match");
		else
			$display("activation_function_unit: mismatch");
		$finish;
	end

endmodule
